// File: rtl/core/sacl_pkg.sv
package sacl_pkg;

    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 32;
    localparam int WAY_OUT_W  = 3;
    localparam int SET_OUT_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int MAX_WAYS_DEF = 8;
    localparam int MAX_SETS_DEF = 256;

    // largest useful register settings
    localparam logic [CFG_DATA_W-1:0] LINE_BITS_MAX = 4'd12;
    localparam logic [CFG_DATA_W-1:0] SET_BITS_MAX  = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS      = 2'd2;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] LINE_BITS_RST = 4'd4;
    localparam logic [CFG_DATA_W-1:0] SET_BITS_RST  = 4'd4;
    localparam logic [CFG_DATA_W-1:0] WAYS_RST      = 4'd4;

endpackage

// File: rtl/core/set_assoc_cache_lookup_fifo_unit.sv
// Set-associative cache lookup with FIFO replacement.
// Input channel: one byte address per word (i_in_valid / o_in_stall). Output
// channel: hit flag, way, set index and the saturating hit and miss totals
// (o_out_valid / i_out_stall). Registers line_bits, set_bits and ways are
// written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
// them only while the block is idle, as the block does not enforce it. Each
// set lives in one row of a synchronous memory holding all tags, the valid
// bits and the FIFO pointer. The accept cycle issues the set read; the lookup
// state then compares all ways at once and, on finishing, writes the row back
// on a miss and loads the result register. No new word is accepted until the
// lookup has finished. The result register lets a new word be accepted while
// the previous result waits; a stalled result holds its value, and the lookup
// stage waits until the result register frees up before finishing. After
// reset a clearing pass walks the memory one row a cycle, over all MAX_SETS
// rows, with o_in_stall high; configuration writes are taken as usual. Reset
// also clears the counters and restores the register defaults.
module set_assoc_cache_lookup_fifo_unit #(
    parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
    parameter int MAX_SETS = sacl_pkg::MAX_SETS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sacl_pkg::ADDR_W-1:0]      i_address,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0]   o_way,
    output logic [sacl_pkg::SET_OUT_W-1:0]   o_set_index,
    output logic [sacl_pkg::CNT_W-1:0]       o_hit_count,
    output logic [sacl_pkg::CNT_W-1:0]       o_miss_count
);
    import sacl_pkg::*;

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W  = $clog2(MAX_WAYS + 1);
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MOD_N = 1 << SET_OUT_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    typedef struct packed {
        logic [WAY_W-1:0]                ptr;
        logic [MAX_WAYS-1:0]             vld;
        logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
    } t_row;

    logic [CFG_DATA_W-1:0] r_line_bits;
    logic [CFG_DATA_W-1:0] r_set_bits;
    logic [CFG_DATA_W-1:0] r_ways;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [SET_W-1:0]      r_clr_idx;
    logic [SET_OUT_W-1:0]  r_set;
    logic [ADDR_W-1:0]     r_block;
    t_row                  r_rd;
    t_row                  r_mem [MAX_SETS];

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [WAY_OUT_W-1:0]  r_out_way;
    logic [SET_OUT_W-1:0]  r_out_set;
    logic [CNT_W-1:0]      r_hits;
    logic [CNT_W-1:0]      r_misses;

    logic [CFG_DATA_W-1:0] w_lb;
    logic [CFG_DATA_W-1:0] w_sb;
    logic [NW_W-1:0]       w_nways;
    logic [ADDR_W-1:0]     w_shift;
    logic [SET_OUT_W-1:0]  w_set_mask;
    logic [SET_OUT_W-1:0]  w_set_raw;
    logic [SET_OUT_W-1:0]  w_mod_tbl [MOD_N];
    logic [SET_OUT_W-1:0]  w_set_used;
    logic [ADDR_W-1:0]     w_block;
    logic                  w_accept;
    logic                  w_done;

    logic                  w_hit;
    logic [WAY_W-1:0]      w_hit_way;
    logic                  w_empty;
    logic [WAY_W-1:0]      w_empty_way;
    logic [WAY_W-1:0]      w_victim;
    logic [NW_W-1:0]       w_victim_inc;
    logic [WAY_W-1:0]      w_way;
    t_row                  w_new_row;

    logic                  w_wr_en;
    logic [SET_W-1:0]      w_wr_idx;
    t_row                  w_wr_row;

    // clamp the register settings to their usable ranges
    always_comb begin
        w_lb = (r_line_bits > LINE_BITS_MAX) ? LINE_BITS_MAX : r_line_bits;
        w_sb = (r_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : r_set_bits;
        if (r_ways == '0) begin
            w_nways = NW_W'(1);
        end else if (int'(r_ways) > MAX_WAYS) begin
            w_nways = NW_W'(MAX_WAYS);
        end else begin
            w_nways = NW_W'(r_ways);
        end
    end

    // set index reduced modulo the number of sets actually built
    for (genvar g = 0; g < MOD_N; g++) begin : g_mod
        assign w_mod_tbl[g] = SET_OUT_W'(g % MAX_SETS);
    end

    assign w_shift    = i_address >> w_lb;
    assign w_set_mask = SET_OUT_W'((9'd1 << w_sb) - 9'd1);
    assign w_set_raw  = w_shift[SET_OUT_W-1:0] & w_set_mask;
    assign w_set_used = w_mod_tbl[w_set_raw];
    assign w_block    = i_address & ~((32'd1 << w_lb) - 32'd1);

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_done     = (r_state == ST_LOOK) && (!r_out_valid || !i_out_stall);

    // compare all ways of the set at once; lowest way wins
    always_comb begin
        w_hit       = 1'b0;
        w_hit_way   = '0;
        w_empty     = 1'b0;
        w_empty_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (NW_W'(w) < w_nways) begin
                if (r_rd.vld[w] && (r_rd.tag[w] == r_block)) begin
                    w_hit     = 1'b1;
                    w_hit_way = WAY_W'(w);
                end
                if (!r_rd.vld[w]) begin
                    w_empty     = 1'b1;
                    w_empty_way = WAY_W'(w);
                end
            end
        end
    end

    // a stale pointer past the ways in use falls back to way 0
    assign w_victim     = (NW_W'(r_rd.ptr) < w_nways) ? r_rd.ptr : '0;
    assign w_victim_inc = NW_W'(w_victim) + NW_W'(1);

    always_comb begin
        w_new_row = r_rd;
        if (w_hit) begin
            w_way = w_hit_way;
        end else if (w_empty) begin
            w_way = w_empty_way;
        end else begin
            w_way         = w_victim;
            w_new_row.ptr = (w_victim_inc == w_nways) ? '0 : WAY_W'(w_victim_inc);
        end
        w_new_row.vld[w_way] = 1'b1;
        w_new_row.tag[w_way] = r_block;
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_wr_en  = 1'b1;
            w_wr_idx = r_clr_idx;
            w_wr_row = '0;
        end else begin
            w_wr_en  = w_done && !w_hit;
            w_wr_idx = SET_W'(r_set);
            w_wr_row = w_new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= w_wr_row;
        end
        if (w_accept) begin
            r_rd <= r_mem[SET_W'(w_set_used)];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == SET_W'(MAX_SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_line_bits <= LINE_BITS_RST;
            r_set_bits  <= SET_BITS_RST;
            r_ways      <= WAYS_RST;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LINE_BITS: r_line_bits <= i_cfg_data;
                    CFG_SET_BITS:  r_set_bits  <= i_cfg_data;
                    CFG_WAYS:      r_ways      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
                if (w_hit) begin
                    r_hits <= (&r_hits) ? r_hits : r_hits + CNT_W'(1);
                end else begin
                    r_misses <= (&r_misses) ? r_misses : r_misses + CNT_W'(1);
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set   <= w_set_used;
            r_block <= w_block;
        end
        if (w_done) begin
            r_out_hit <= w_hit;
            r_out_way <= WAY_OUT_W'(w_way);
            r_out_set <= r_set;
        end
    end

    // totals only move when a new word is loaded, so they hold while stalled
    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_way        = r_out_way;
    assign o_set_index  = r_out_set;
    assign o_hit_count  = r_hits;
    assign o_miss_count = r_misses;

endmodule
